>>> rtl/robin_hood_hash_set_unit_assert.svh
// Assertion macros shared by the checker files.
`ifndef ROBIN_HOOD_HASH_SET_UNIT_ASSERT_SVH
`define ROBIN_HOOD_HASH_SET_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/rhhs_pkg.sv
// Package with types, constants and the key hash of the robin hood hash set.
`timescale 1ns / 1ps
package rhhs_pkg;
  localparam int unsigned KeyW = 64;
  localparam int unsigned HashW = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // Item handed from the front to the back part.
  typedef struct packed {
    op_e              op;
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] hash;
  } cmd_t;

  localparam logic [63:0] HashAdd = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HashMul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HashMul2 = 64'h94d049bb133111eb;

  typedef enum logic [3:0] {
    BK_IDLE, BK_SCAN, BK_PROBE_RD, BK_PROBE, BK_INS_WR, BK_SHIFT_RD, BK_SHIFT,
    BK_FINISH, BK_OUT
  } bk_state_e;
endpackage

>>> rtl/robin_hood_hash_set_unit.sv
// Top level of the robin hood hash set unit.
// Robin hood hash set of keys with backward-shift delete.
// Slave stream s_axis carries one operation per transaction; m_axis returns one
// result per operation, in order. Config port cfg_we_i/cfg_wdata_i sets the
// log2 of the slots in use (3..8, reset 8); write it only while idle.
// The front hashes the key, then the back walker runs: an insert
// scans the valid bits (one slot a cycle until a free one shows), then
// probes the visited slots and displaces entries; a lookup probes slots
// in turn; a remove also shifts the following entries back.
// The front takes no new transaction until the queue has accepted its last
// hashed item; hash front and table back are decoupled by a two-entry
// queue, so the next key is hashed while the table is walked.
// Reset clears all valid bits at once and the entry count; no clearing pass.
// A stalled m_axis receiver holds the result; the walker then stops taking
// new work and the queue and front fill and deassert s_axis_tready.
`timescale 1ns / 1ps
module robin_hood_hash_set_unit #(
  parameter int unsigned CAPACITY  = 256,
  parameter int unsigned KEY_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // [1:0] opcode, [65:2] key, [71:66] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // [1:0] status, [9:2] slot, [18:10] entry_count
);
  import rhhs_pkg::*;

  logic [3:0] cap_q;
  cmd_t       f_cmd, q_cmd;
  logic       f_valid, f_ready, q_valid, q_ready;
  logic [1:0] st;
  logic [7:0] sl;
  logic [8:0] ec;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= 4'd8;
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  rhhs_front #(.KeyWidth(KEY_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_op_i(s_axis_tdata[1:0]), .in_key_i(s_axis_tdata[65:2]),
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  rhhs_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i(f_cmd),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_cmd)
  );

  rhhs_back #(.Capacity(CAPACITY)) u_back (
    .clk_i, .rst_ni, .cap_log2_i(cap_q),
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_status_o(st), .res_slot_o(sl), .res_count_o(ec)
  );

  assign m_axis_tdata = {5'd0, ec, sl, st};
endmodule

>>> rtl/rhhs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rhhs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/rhhs_front.sv
// Front part: accepts items, masks the key and hashes it in a multiplier pipeline.
`timescale 1ns / 1ps
module rhhs_front #(
  parameter int unsigned KeyWidth = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       in_op_i,
  input  logic [63:0]      in_key_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output rhhs_pkg::cmd_t   cmd_o
);
  import rhhs_pkg::*;

  // Pipeline: add on accept, stage0 xor-shift, stage1..4 two 64x64 products split into 32-bit halves
  logic [2:0]       stg_q, stg_d;
  logic             busy_q;
  logic [1:0]       op_q;
  logic [63:0]      key_q, z_q, x_q;
  logic [63:0]      plo_q, pmid_q;
  logic             mul_sel_q;
  logic [63:0]      kmasked;
  logic [63:0]      mul_c;
  logic [63:0]      lo_prod, mid_prod, cross_prod;
  logic             fire;

  assign kmasked = (KeyWidth >= 64) ? in_key_i
                   : (in_key_i & ((64'd1 << KeyWidth) - 64'd1));
  assign in_ready_o = !busy_q;
  assign fire = in_valid_i && in_ready_o;
  assign mul_c = mul_sel_q ? HashMul2 : HashMul1;

  // 32x32 partial products; only the low 64 bits of the full product matter
  assign lo_prod    = {32'd0, x_q[31:0]} * {32'd0, mul_c[31:0]};
  assign mid_prod   = {32'd0, x_q[63:32]} * {32'd0, mul_c[31:0]};
  assign cross_prod = {32'd0, x_q[31:0]} * {32'd0, mul_c[63:32]};

  assign stg_d = stg_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      stg_q       <= '0;
      cmd_valid_o <= 1'b0;
      mul_sel_q   <= 1'b0;
    end else begin
      if (fire) begin
        busy_q    <= 1'b1;
        stg_q     <= '0;
        mul_sel_q <= 1'b0;
      end else if (busy_q && !cmd_valid_o) begin
        stg_q <= stg_d;
        case (stg_q)
          3'd2: mul_sel_q <= 1'b1;
          3'd4: cmd_valid_o <= 1'b1;
          default: ;
        endcase
      end else if (cmd_valid_o && cmd_ready_i) begin
        cmd_valid_o <= 1'b0;
        busy_q      <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (fire) begin
      op_q  <= in_op_i;
      key_q <= kmasked;
      z_q   <= kmasked + HashAdd;
    end else if (busy_q && !cmd_valid_o) begin
      case (stg_q)
        3'd0: x_q <= z_q ^ (z_q >> 30);
        3'd1: begin
          plo_q  <= lo_prod;
          pmid_q <= mid_prod + cross_prod;
        end
        3'd2: begin
          z_q <= plo_q + {pmid_q[31:0], 32'd0};
          x_q <= (plo_q + {pmid_q[31:0], 32'd0})
                 ^ ((plo_q + {pmid_q[31:0], 32'd0}) >> 27);
        end
        3'd3: begin
          plo_q  <= lo_prod;
          pmid_q <= mid_prod + cross_prod;
        end
        3'd4: z_q <= plo_q + {pmid_q[31:0], 32'd0};
        default: ;
      endcase
    end
  end

  logic [63:0] zf;
  assign zf = z_q ^ (z_q >> 31);
  assign cmd_o.op = op_e'(op_q);
  assign cmd_o.key = key_q;
  assign cmd_o.hash = zf[63:32];
endmodule

>>> rtl/rhhs_queue.sv
// Two-entry queue between front and back parts.
`timescale 1ns / 1ps
module rhhs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rhhs_pkg::cmd_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rhhs_pkg::cmd_t out_data_o
);
  import rhhs_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rp_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end
endmodule

>>> rtl/rhhs_back.sv
// Back part: table walker for insert, lookup and backward-shift remove.
`timescale 1ns / 1ps
module rhhs_back #(
  parameter int unsigned Capacity = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [3:0]     cap_log2_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  rhhs_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic [1:0]     res_status_o,
  output logic [7:0]     res_slot_o,
  output logic [8:0]     res_count_o
);
  import rhhs_pkg::*;

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = AW + 1;
  // Log2 of the largest power of two not above the capacity
  localparam int unsigned MaxLg = $clog2(Capacity + 1) - 1;

  bk_state_e st_q, st_d;

  // Valid bits in flip-flops, key and hash in RAMs
  logic [Capacity-1:0] valid_q;
  logic [AW-1:0]   mask;
  logic [AW-1:0]   pos_q, cur_q, res_slot_q, scan_q;
  logic [CW-1:0]   steps_q, cnt_q;
  logic [AW-1:0]   dist_q;
  logic            placed_q;
  logic [KeyW-1:0] ck_q;
  logic [HashW-1:0] ch_q;
  logic [1:0]      status_q;
  op_e             op_q;
  logic            space_q;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [KeyW-1:0] wkey, rkey;
  logic [HashW-1:0] whash, rhash;

  // Effective mask from the clamped register
  always_comb begin
    logic [3:0] lg;
    lg = cap_log2_i;
    if (lg < 4'd3) lg = 4'd3;
    if (32'(lg) > MaxLg) lg = 4'(MaxLg);
    mask = AW'((CW'(1) << lg) - CW'(1));
  end

  rhhs_ram #(.Width(KeyW), .Depth(Capacity)) u_key_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wkey), .raddr_i(raddr), .rdata_o(rkey)
  );
  rhhs_ram #(.Width(HashW), .Depth(Capacity)) u_hash_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(whash), .raddr_i(raddr), .rdata_o(rhash)
  );

  logic [AW-1:0] nxt_pos, rdist, home;
  logic          vpos;
  assign nxt_pos = (pos_q + AW'(1)) & mask;
  assign vpos    = valid_q[pos_q];
  assign rdist   = (pos_q - AW'(rhash)) & mask;
  assign home    = AW'(cmd_i.hash) & mask;

  assign cmd_ready_o  = st_q == BK_IDLE;
  assign res_valid_o  = st_q == BK_OUT;
  assign res_status_o = status_q;
  assign res_slot_o   = 8'(res_slot_q);
  assign res_count_o  = 9'(cnt_q);

  // Next state and RAM port control
  always_comb begin
    st_d  = st_q;
    we    = 1'b0;
    waddr = pos_q;
    wkey  = ck_q;
    whash = ch_q;
    raddr = pos_q;
    unique case (st_q)
      BK_IDLE: if (cmd_valid_i) begin
        unique case (cmd_i.op)
          OP_INSERT: st_d = BK_SCAN;
          OP_LOOKUP, OP_REMOVE: st_d = BK_PROBE_RD;
          default: st_d = BK_OUT;
        endcase
      end
      BK_SCAN: begin
        if (space_q || !valid_q[scan_q]) st_d = BK_PROBE_RD;
        else if (scan_q == mask) st_d = BK_OUT;
      end
      BK_PROBE_RD: st_d = BK_PROBE;
      BK_PROBE: begin
        if (op_q == OP_INSERT) begin
          if (!vpos) begin
            we = 1'b1;
            st_d = BK_FINISH;
          end else if (dist_q > rdist) begin
            we = 1'b1;
            st_d = BK_INS_WR;
          end else if (steps_q == CW'(mask)) st_d = BK_FINISH;
          else begin
            raddr = nxt_pos;
            st_d = BK_PROBE;
          end
        end else begin
          if (!vpos) st_d = BK_OUT;
          else if (steps_q != '0 && dist_q > rdist) st_d = BK_OUT;
          else if (rhash == ch_q && rkey == ck_q) begin
            st_d = (op_q == OP_REMOVE) ? BK_SHIFT_RD : BK_OUT;
          end else if (steps_q == CW'(mask)) st_d = BK_OUT;
          else begin
            raddr = nxt_pos;
            st_d = BK_PROBE;
          end
        end
      end
      BK_INS_WR: begin
        if (steps_q == CW'(mask) + CW'(1)) st_d = BK_FINISH;
        else begin
          raddr = pos_q;
          st_d = BK_PROBE;
        end
      end
      BK_SHIFT_RD: st_d = BK_SHIFT;
      BK_SHIFT: begin
        if (!vpos || rdist == '0 || steps_q > CW'(mask)) st_d = BK_FINISH;
        else begin
          we    = 1'b1;
          waddr = cur_q;
          wkey  = rkey;
          whash = rhash;
          raddr = nxt_pos;
          st_d  = BK_SHIFT;
        end
      end
      BK_FINISH: st_d = BK_OUT;
      BK_OUT: if (res_ready_i) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BK_IDLE;
    else st_q <= st_d;
  end

  // Control and walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      cnt_q    <= '0;
      status_q <= ST_NOTFOUND;
      res_slot_q <= '0;
      op_q     <= OP_NONE;
      pos_q    <= '0;
      cur_q    <= '0;
      steps_q  <= '0;
      dist_q   <= '0;
      placed_q <= 1'b0;
      scan_q   <= '0;
      space_q  <= 1'b0;
      ck_q     <= '0;
      ch_q     <= '0;
    end else begin
      unique case (st_q)
        BK_IDLE: if (cmd_valid_i) begin
          op_q     <= cmd_i.op;
          ck_q     <= cmd_i.key;
          ch_q     <= cmd_i.hash;
          pos_q    <= home;
          steps_q  <= '0;
          dist_q   <= '0;
          placed_q <= 1'b0;
          scan_q   <= '0;
          space_q  <= 1'b0;
          status_q <= ST_NOTFOUND;
          res_slot_q <= '0;
        end
        BK_SCAN: begin
          if (!valid_q[scan_q]) space_q <= 1'b1;
          else if (scan_q == mask && !space_q) status_q <= ST_FULL;
          scan_q <= scan_q + AW'(1);
        end
        BK_PROBE: begin
          if (op_q == OP_INSERT) begin
            if (!vpos) begin
              valid_q[pos_q] <= 1'b1;
              if (!placed_q) res_slot_q <= pos_q;
              status_q <= ST_DONE;
              if (cnt_q < CW'(Capacity)) cnt_q <= cnt_q + CW'(1);
            end else if (dist_q > rdist) begin
              ck_q   <= rkey;
              ch_q   <= rhash;
              dist_q <= rdist + AW'(1);
              if (!placed_q) begin
                res_slot_q <= pos_q;
                placed_q   <= 1'b1;
              end
              pos_q   <= nxt_pos;
              steps_q <= steps_q + CW'(1);
            end else begin
              if (steps_q == CW'(mask)) begin
                status_q <= ST_DONE;
                if (cnt_q < CW'(Capacity)) cnt_q <= cnt_q + CW'(1);
              end
              pos_q   <= nxt_pos;
              dist_q  <= dist_q + AW'(1);
              steps_q <= steps_q + CW'(1);
            end
          end else begin
            if (!vpos) ;
            else if (steps_q != '0 && dist_q > rdist) ;
            else if (rhash == ch_q && rkey == ck_q) begin
              status_q   <= ST_DONE;
              res_slot_q <= pos_q;
              cur_q      <= pos_q;
              pos_q      <= nxt_pos;
              steps_q    <= CW'(1);
            end else begin
              pos_q   <= nxt_pos;
              dist_q  <= dist_q + AW'(1);
              steps_q <= steps_q + CW'(1);
            end
          end
        end
        BK_INS_WR: begin
          if (steps_q == CW'(mask) + CW'(1)) begin
            status_q <= ST_DONE;
            if (cnt_q < CW'(Capacity)) cnt_q <= cnt_q + CW'(1);
          end
        end
        BK_SHIFT: begin
          if (!vpos || rdist == '0 || steps_q > CW'(mask)) begin
            valid_q[cur_q] <= 1'b0;
            if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
          end else begin
            cur_q   <= pos_q;
            pos_q   <= nxt_pos;
            steps_q <= steps_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/rhhs_checker.sv
// Port-level checker for the hash set unit, bound to the top level.
`timescale 1ns / 1ps
`include "robin_hood_hash_set_unit_assert.svh"
module rhhs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import rhhs_pkg::*;

  `RH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `RH_ASSERT_IMPL(a_status_code, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[1:0] <= ST_FULL)
  `RH_ASSERT_IMPL(a_slot_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[1:0] != ST_DONE, m_axis_tdata[9:2] == 8'd0)
  `RH_ASSERT_IMPL(a_count_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[18:10] <= 9'd256)
endmodule

bind robin_hood_hash_set_unit rhhs_checker u_rhhs_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
